// ===== src/mps_pkg.sv =====
// Shared types and constants for the multiplexed servo pulse sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mps_pkg;

    localparam int PINS_W  = 4;
    localparam int SLOT_W  = 3;
    localparam int TICKS_W = 16;
    localparam int POS_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_THIGH_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOT_CENTER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL  = 2'd2;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [7:0]         RESET_THIGH = 8'd100;
    localparam logic [7:0]         RESET_FOOT  = 8'd90;
    localparam logic [11:0]        RESET_FRAME = 12'd1500;
    localparam logic [TICKS_W-1:0] RESET_TICKS = 16'd180;

    // reciprocal of 3 scaled by 2^9, exact for magnitudes up to 255
    localparam logic [15:0] RECIP3     = 16'd171;
    localparam int          RECIP3_SHR = 9;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic [SLOT_W-1:0] slot;
        logic              period_end;
    } t_result;

endpackage

`default_nettype wire

// ===== src/mps_pos_calc.sv =====
// Servo position calculation from an acceleration pair: x/2 and y/3
// toward zero, added to the centers and clamped. Uses mps_pkg.
`default_nettype none

module mps_pos_calc
    import mps_pkg::*;
(
    input  wire logic signed [7:0]       i_accel_x,
    input  wire logic signed [7:0]       i_accel_y,
    input  wire logic        [7:0]       i_thigh_center,
    input  wire logic        [7:0]       i_foot_center,
    output logic             [POS_W-1:0] o_thigh_pos,
    output logic             [POS_W-1:0] o_foot_pos
);

    logic signed [7:0]  x_adj;
    logic signed [7:0]  x_half;
    logic        [7:0]  y_mag;
    logic        [15:0] y_prod;
    logic        [6:0]  y_q;
    logic signed [7:0]  y_third;
    logic signed [9:0]  thigh_sum;
    logic signed [9:0]  foot_sum;

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [9:0] v);
        // sums stay below 512, so only the low side needs clamping
        if (v < 0) begin
            return '0;
        end
        return v[POS_W-1:0];
    endfunction

    always_comb begin
        // bias negatives by one so the arithmetic shift truncates toward zero
        x_adj  = i_accel_x + $signed({7'b0, i_accel_x[7]});
        x_half = x_adj >>> 1;

        y_mag   = i_accel_y[7] ? 8'(-i_accel_y) : 8'(i_accel_y);
        y_prod  = {8'b0, y_mag} * RECIP3;
        y_q     = y_prod[RECIP3_SHR+6:RECIP3_SHR];
        y_third = i_accel_y[7] ? -$signed({1'b0, y_q}) : $signed({1'b0, y_q});

        thigh_sum = $signed({2'b0, i_thigh_center}) + $signed({{2{x_half[7]}}, x_half});
        foot_sum  = $signed({2'b0, i_foot_center}) + $signed({{2{y_third[7]}}, y_third});

        o_thigh_pos = clamp_pos(thigh_sum);
        o_foot_pos  = clamp_pos(foot_sum);
    end

endmodule

`default_nettype wire

// ===== src/mps_frame_timer.sv =====
// Frame timer: slot counter, tick countdown, pin levels and servo positions.
// Produces the next result word for each accepted word. Uses mps_pkg.
`default_nettype none

module mps_frame_timer
    import mps_pkg::*;
#(
    parameter int SERVO_COUNT = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic             i_opcode,
    input  wire logic [POS_W-1:0] i_thigh_pos,
    input  wire logic [POS_W-1:0] i_foot_pos,
    input  wire logic [11:0]      i_frame_total,
    output t_result               o_res
);

    localparam int SW   = $clog2(SERVO_COUNT + 1);
    localparam int IW   = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam int SUMW = $clog2(SERVO_COUNT * 511 + 1);
    localparam int CW   = ((SUMW > 12) ? SUMW : 12) + 1;
    localparam int PW   = (SERVO_COUNT > PINS_W) ? SERVO_COUNT : PINS_W;
    localparam int SLW  = (SW > SLOT_W) ? SW : SLOT_W;
    localparam logic [SW-1:0] SLOT_GAP = SW'(SERVO_COUNT);

    logic [SW-1:0]          r_slot, n_slot;
    logic [TICKS_W-1:0]     r_ticks, n_ticks;
    logic [SERVO_COUNT-1:0] r_pins, n_pins;
    logic [POS_W-1:0]       r_pos [SERVO_COUNT];
    logic [POS_W-1:0]       n_pos [SERVO_COUNT];

    logic [SUMW-1:0]        pos_sum;
    logic [CW-1:0]          gap_diff;
    logic [CW+3:0]          gap_scaled;
    logic [TICKS_W-1:0]     gap_ticks;
    logic [IW-1:0]          pos_idx;
    logic                   ended;
    logic [PW-1:0]          pins_wide;
    logic [SLW-1:0]         slot_wide;

    always_comb begin
        pos_sum = '0;
        for (int i = 0; i < SERVO_COUNT; i++) begin
            pos_sum = pos_sum + SUMW'(r_pos[i]);
        end
        gap_diff   = CW'(i_frame_total) - CW'(pos_sum);
        gap_scaled = {gap_diff, 4'b0};
        gap_ticks  = (CW'(pos_sum) >= CW'(i_frame_total)) ? '0 : gap_scaled[TICKS_W-1:0];
    end

    always_comb begin
        n_slot  = r_slot;
        n_ticks = r_ticks;
        n_pins  = r_pins;
        n_pos   = r_pos;
        ended   = 1'b0;
        pos_idx = '0;
        if (i_step) begin
            if (i_opcode == OP_UPDATE) begin
                for (int i = 0; i < SERVO_COUNT; i++) begin
                    n_pos[i] = (i == 1 || i == 2) ? i_thigh_pos : i_foot_pos;
                end
            end else if (r_ticks == '0) begin
                ended  = 1'b1;
                n_slot = (r_slot == SLOT_GAP) ? '0 : r_slot + SW'(1);
                if (n_slot == SLOT_GAP) begin
                    n_pins  = '0;
                    n_ticks = gap_ticks;
                end else begin
                    pos_idx = n_slot[IW-1:0];
                    n_pins  = SERVO_COUNT'(1) << pos_idx;
                    n_ticks = TICKS_W'({r_pos[pos_idx], 5'b0});
                end
            end else begin
                n_ticks = r_ticks - TICKS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_ticks <= RESET_TICKS;
            r_pins  <= '0;
            for (int i = 0; i < SERVO_COUNT; i++) begin
                r_pos[i] <= (i == 1 || i == 2) ? POS_W'(RESET_THIGH) : POS_W'(RESET_FOOT);
            end
        end else if (i_step) begin
            r_slot  <= n_slot;
            r_ticks <= n_ticks;
            r_pins  <= n_pins;
            r_pos   <= n_pos;
        end
    end

    always_comb begin
        pins_wide        = PW'(n_pins);
        slot_wide        = SLW'(n_slot);
        o_res.pins       = pins_wide[PINS_W-1:0];
        o_res.slot       = slot_wide[SLOT_W-1:0];
        o_res.period_end = ended;
    end

endmodule

`default_nettype wire

// ===== src/multiplexed_servo_pulse_sequencer.sv =====
// Top level of the multiplexed servo pulse sequencer: config registers,
// input handshake and result register. Uses mps_pkg, mps_pos_calc, mps_frame_timer.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  in      | in        | i_in_valid/o_in_stall | i_opcode, i_accel_x, i_accel_y
//  out     | out       | o_out_valid/i_out_stall| o_servo_pins, o_slot, o_period_end
//  cfg     | in        | i_cfg_we              | i_cfg_index, i_cfg_data
//
// One word per cycle while the input is not stalled: a word is worked in the cycle
// it is accepted and its result sits in the output register from the next cycle.
// The input stalls only while a result is held and the output is stalled.
// Reset restores the centers, the frame total, slot 0, 180 ticks and the
// reset positions; it needs no clearing pass.
`default_nettype none

module multiplexed_servo_pulse_sequencer
    import mps_pkg::*;
#(
    parameter int SERVO_COUNT = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_opcode,
    input  wire logic signed [7:0]     i_accel_x,
    input  wire logic signed [7:0]     i_accel_y,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [PINS_W-1:0]          o_servo_pins,
    output logic [SLOT_W-1:0]          o_slot,
    output logic                       o_period_end,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [7:0]       r_thigh_center;
    logic [7:0]       r_foot_center;
    logic [11:0]      r_frame_total;
    logic             r_out_valid, n_out_valid;
    t_result          r_res;
    t_result          step_res;
    logic             accept;
    logic [POS_W-1:0] thigh_pos;
    logic [POS_W-1:0] foot_pos;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thigh_center <= RESET_THIGH;
            r_foot_center  <= RESET_FOOT;
            r_frame_total  <= RESET_FRAME;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THIGH_CENTER: r_thigh_center <= i_cfg_data[7:0];
                CFG_FOOT_CENTER:  r_foot_center  <= i_cfg_data[7:0];
                CFG_FRAME_TOTAL:  r_frame_total  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    mps_pos_calc u_pos_calc (
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_thigh_center (r_thigh_center),
        .i_foot_center  (r_foot_center),
        .o_thigh_pos    (thigh_pos),
        .o_foot_pos     (foot_pos)
    );

    mps_frame_timer #(
        .SERVO_COUNT (SERVO_COUNT)
    ) u_frame_timer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (accept),
        .i_opcode      (i_opcode),
        .i_thigh_pos   (thigh_pos),
        .i_foot_pos    (foot_pos),
        .i_frame_total (r_frame_total),
        .o_res         (step_res)
    );

    always_comb begin
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (accept) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_servo_pins = r_res.pins;
    assign o_slot       = r_res.slot;
    assign o_period_end = r_res.period_end;

endmodule

`default_nettype wire

// ===== dv/tb_multiplexed_servo_pulse_sequencer.sv =====
// Self-checking testbench for multiplexed_servo_pulse_sequencer: a frame timer and
// position predictor in a small scoreboard class, random idling on both channels.
// Depends on mps_pkg and the block's top level only.

module tb_multiplexed_servo_pulse_sequencer;
    import mps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SERVOS  = 4;
    localparam int POS_MAX     = (1 << POS_W) - 1;
    localparam int CYCLE_LIMIT = 400_000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    class servo_frame_scoreboard;
        logic [7:0]         thigh_center;
        logic [7:0]         foot_center;
        logic [11:0]        frame_total;
        logic [SLOT_W-1:0]  slot_q;
        logic [TICKS_W-1:0] ticks_left;
        logic [POS_W-1:0]   position [NUM_SERVOS];
        logic [PINS_W-1:0]  pin_levels;
        t_result            expected_q [$];
        int                 mismatches;

        function new();
            thigh_center = RESET_THIGH;
            foot_center  = RESET_FOOT;
            frame_total  = RESET_FRAME;
            slot_q       = '0;
            ticks_left   = RESET_TICKS;
            pin_levels   = '0;
            mismatches   = 0;
            for (int i = 0; i < NUM_SERVOS; i++)
                position[i] = is_thigh(i) ? POS_W'(RESET_THIGH) : POS_W'(RESET_FOOT);
        endfunction

        function bit is_thigh(int i);
            return i == 1 || i == 2;
        endfunction

        function logic [POS_W-1:0] clamp_pos(int v);
            if (v < 0)
                return '0;
            if (v > POS_MAX)
                return POS_W'(POS_MAX);
            return v[POS_W-1:0];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THIGH_CENTER: thigh_center = data[7:0];
                CFG_FOOT_CENTER:  foot_center  = data[7:0];
                CFG_FRAME_TOTAL:  frame_total  = data[11:0];
                default: ;
            endcase
        endfunction

        // new slot just entered: servo slots raise their pin, the gap fills the frame
        function void load_slot();
            int sum;
            int ft;
            pin_levels = '0;
            if (slot_q == NUM_SERVOS) begin
                sum = 0;
                ft  = int'(frame_total);
                for (int i = 0; i < NUM_SERVOS; i++)
                    sum += int'(position[i]);
                if (sum >= ft)
                    ticks_left = '0;
                else
                    ticks_left = TICKS_W'(16 * (ft - sum));
            end else begin
                pin_levels = PINS_W'(1 << slot_q);
                ticks_left = TICKS_W'(32 * int'(position[slot_q]));
            end
        endfunction

        function void note_word(logic op, logic signed [7:0] ax, logic signed [7:0] ay);
            t_result          r;
            logic [POS_W-1:0] thigh;
            logic [POS_W-1:0] foot;
            r.period_end = 1'b0;
            if (op == OP_UPDATE) begin
                // int division truncates toward zero
                thigh = clamp_pos(int'(thigh_center) + int'(ax) / 2);
                foot  = clamp_pos(int'(foot_center) + int'(ay) / 3);
                for (int i = 0; i < NUM_SERVOS; i++)
                    position[i] = is_thigh(i) ? thigh : foot;
            end else if (ticks_left == '0) begin
                r.period_end = 1'b1;
                slot_q = (slot_q == NUM_SERVOS) ? '0 : slot_q + 1'b1;
                load_slot();
            end else begin
                ticks_left = ticks_left - 1'b1;
            end
            r.pins = pin_levels;
            r.slot = slot_q;
            expected_q.push_back(r);
        endfunction

        function void check_word(logic [PINS_W-1:0] pins, logic [SLOT_W-1:0] slot,
                                 logic period_end);
            t_result want;
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected word: pins %h slot %0d period_end %b",
                             pins, slot, period_end);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (want.pins !== pins || want.slot !== slot || want.period_end !== period_end) begin
                if (mismatches < 10)
                    $display("mismatch at %0t: pins %h/%h slot %0d/%0d period_end %b/%b (exp/act)",
                             $realtime, want.pins, pins, want.slot, slot,
                             want.period_end, period_end);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_opcode = OP_TICK;
    logic signed [7:0]       i_accel_x = '0;
    logic signed [7:0]       i_accel_y = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [PINS_W-1:0]       o_servo_pins;
    logic [SLOT_W-1:0]       o_slot;
    logic                    o_period_end;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    servo_frame_scoreboard sb;
    bit quiet = 1'b0;
    int stall_left = 0;
    int cycle_count = 0;

    multiplexed_servo_pulse_sequencer #(.SERVO_COUNT(NUM_SERVOS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_servo_pins (o_servo_pins),
        .o_slot       (o_slot),
        .o_period_end (o_period_end),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: check accepted words, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word(o_servo_pins, o_slot, o_period_end);
        if (quiet) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_word(input logic op, input logic [7:0] ax, input logic [7:0] ay);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_accel_x  <= ax;
        i_accel_y  <= ay;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_word(op, ax, ay);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // block is idle here; the last write goes to the unused index
    task automatic set_config(input logic [7:0] th, input logic [7:0] fc,
                              input logic [11:0] ft);
        logic [CFG_IDX_W-1:0]  idx  [4];
        logic [CFG_DATA_W-1:0] vals [4];
        idx  = '{CFG_THIGH_CENTER, CFG_FOOT_CENTER, CFG_FRAME_TOTAL, CFG_UNUSED};
        vals = '{CFG_DATA_W'(th), CFG_DATA_W'(fc), ft, CFG_DATA_W'($urandom)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            sb.write_reg(idx[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // mostly negative accel: with small centers the positions stay near zero
    function automatic logic [7:0] small_accel();
        return 8'($urandom_range(0, 132) - 128);
    endfunction

    task automatic run_random(input int count, input bit updates_only);
        int pick;
        send_word(OP_UPDATE, small_accel(), small_accel());
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (updates_only || pick < 25) begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    // full-range word, pulled back before a load can pick it up
                    send_word(OP_UPDATE, 8'($urandom), 8'($urandom));
                    send_word(OP_UPDATE, small_accel(), small_accel());
                end else if (pick == 2) begin
                    send_word(OP_UPDATE, 8'($urandom_range(0, 160) - 128),
                              8'($urandom_range(0, 160) - 128));
                end else begin
                    send_word(OP_UPDATE, small_accel(), small_accel());
                end
            end else begin
                send_word(OP_TICK, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: field extremes, truncation toward zero, mid-period ticks
        send_word(OP_TICK, 8'h00, 8'h00);
        send_word(OP_UPDATE, 8'h80, 8'h80);
        send_word(OP_UPDATE, 8'h7F, 8'h7F);
        send_word(OP_UPDATE, 8'hFF, 8'hFF);
        send_word(OP_UPDATE, 8'hFD, 8'hFB);
        send_word(OP_UPDATE, 8'h03, 8'h05);
        send_word(OP_TICK, 8'hFF, 8'h80);
        send_word(OP_UPDATE, 8'h00, 8'h00);
        send_word(OP_TICK, 8'h7F, 8'h01);
        drain();

        // zero frame total forces a one-tick gap; max settings only see updates
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_config(8'd0, 8'd0, 12'd0);
                1: set_config(8'd255, 8'd255, 12'd4095);
                2: set_config(8'd1, 8'd0, 12'd6);
                3: set_config(8'd0, 8'd2, 12'd12);
                7: set_config(8'd0, 8'd1, 12'd8);
                default: set_config(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                                    12'($urandom_range(0, 24)));
            endcase
            quiet = (p == 7);
            run_random((p == 1) ? 20 : 210, p == 1);
            drain();
        end

        repeat (5) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
